### src/cmtb_pkg.sv
// Shared types, constants and register codes for the tile row blitter.
package cmtb_pkg;

  localparam int TILE_SIZE = 8;
  localparam int LANE_W    = $clog2(TILE_SIZE);
  localparam int CNT_W     = $clog2(TILE_SIZE) + 1;
  localparam int PIX_W     = TILE_SIZE * 8;
  localparam int ADDR_W    = 24;
  localparam int COORD_W   = 16;
  localparam int SIZE_W    = 13;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [COORD_W-1:0] CLIP_LEFT_RST   = '0;
  localparam logic signed [COORD_W-1:0] CLIP_TOP_RST    = '0;
  localparam logic [SIZE_W-1:0]         CLIP_WIDTH_RST  = 13'd320;
  localparam logic [SIZE_W-1:0]         CLIP_HEIGHT_RST = 13'd240;
  localparam logic [SIZE_W-1:0]         LINE_WIDTH_RST  = 13'd320;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLIP_LEFT,
    REG_CLIP_TOP,
    REG_CLIP_WIDTH,
    REG_CLIP_HEIGHT,
    REG_LINE_WIDTH
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] clip_left;
    logic signed [COORD_W-1:0] clip_top;
    logic [SIZE_W-1:0]         clip_width;
    logic [SIZE_W-1:0]         clip_height;
    logic [SIZE_W-1:0]         line_width;
  } cfg_t;

  // Visible row after clipping: line y, first visible screen x, run start and length.
  typedef struct packed {
    logic signed [COORD_W:0] y;
    logic signed [COORD_W:0] x0;
    logic [LANE_W-1:0]       lo;
    logic [CNT_W-1:0]        n;
    logic [PIX_W-1:0]        pixels;
    logic [TILE_SIZE-1:0]    mask;
    logic                    use_mask;
  } row_t;

endpackage

### src/cmtb_ifs.sv
// Valid/ready channel interfaces for tile rows and framebuffer writes.
interface cmtb_row_if;
  import cmtb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] tile_x;
  logic signed [COORD_W-1:0] tile_y;
  logic [LANE_W-1:0]         row_index;
  logic [PIX_W-1:0]          row_pixels;
  logic [TILE_SIZE-1:0]      row_mask;
  logic                      use_mask;

  modport source (output valid, tile_x, tile_y, row_index, row_pixels, row_mask,
                  use_mask, input ready);
  modport sink (input valid, tile_x, tile_y, row_index, row_pixels, row_mask,
                use_mask, output ready);
endinterface

interface cmtb_write_if;
  import cmtb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ADDR_W-1:0]    write_address;
  logic [PIX_W-1:0]     write_pixels;
  logic [TILE_SIZE-1:0] write_enables;

  modport source (output valid, write_address, write_pixels, write_enables,
                  input ready);
  modport sink (input valid, write_address, write_pixels, write_enables,
                output ready);
endinterface

### src/cmtb_clip.sv
// Clip stages: line and column offsets, then rectangle test and run clamp.
module cmtb_clip
  import cmtb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  cmtb_row_if.sink     in_item,
  output logic         row_valid,
  input  logic         row_ready,
  output row_t         row
);

  // stage 1 registers
  logic                      v1;
  logic signed [COORD_W-1:0] tx1;
  logic signed [COORD_W:0]   y1;
  logic signed [COORD_W:0]   first1;
  logic signed [COORD_W+1:0] last1;
  logic [PIX_W-1:0]          pix1;
  logic [TILE_SIZE-1:0]      mask1;
  logic                      um1;

  logic ready1;
  logic ready2;

  assign ready2       = !row_valid || row_ready;
  assign ready1       = !v1 || ready2;
  assign in_item.ready = ready1;

  logic signed [COORD_W:0]   y_c;
  logic signed [COORD_W:0]   first_c;
  logic signed [COORD_W+1:0] last_c;

  always_comb begin
    y_c     = $signed({in_item.tile_y[COORD_W-1], in_item.tile_y})
              + $signed({{(COORD_W+1-LANE_W){1'b0}}, in_item.row_index});
    first_c = $signed({cfg.clip_left[COORD_W-1], cfg.clip_left})
              - $signed({in_item.tile_x[COORD_W-1], in_item.tile_x});
    last_c  = $signed({{2{cfg.clip_left[COORD_W-1]}}, cfg.clip_left})
              + $signed({{(COORD_W+2-SIZE_W){1'b0}}, cfg.clip_width})
              - $signed({{2{in_item.tile_x[COORD_W-1]}}, in_item.tile_x});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_item.valid;
    end
    if (ready1 && in_item.valid) begin
      tx1    <= in_item.tile_x;
      y1     <= y_c;
      first1 <= first_c;
      last1  <= last_c;
      pix1   <= in_item.row_pixels;
      mask1  <= in_item.row_mask;
      um1    <= in_item.use_mask;
    end
  end

  // stage 2: vertical test, clamp to the tile, drop rows with nothing visible
  logic signed [COORD_W+1:0] top_s;
  logic signed [COORD_W+1:0] bottom_s;
  logic signed [COORD_W+1:0] y_s;
  logic signed [COORD_W+1:0] first_s;
  logic signed [COORD_W+1:0] last_s;
  logic                      y_in;
  logic                      visible;
  logic [LANE_W-1:0]         lo_c;
  logic [CNT_W-1:0]          n_c;

  always_comb begin
    top_s    = $signed({{2{cfg.clip_top[COORD_W-1]}}, cfg.clip_top});
    bottom_s = top_s + $signed({{(COORD_W+2-SIZE_W){1'b0}}, cfg.clip_height});
    y_s      = $signed({y1[COORD_W], y1});
    y_in     = (y_s >= top_s) && (y_s < bottom_s);
    first_s  = (first1 < 0) ? '0 : $signed({first1[COORD_W], first1});
    last_s   = (last1 > $signed((COORD_W+2)'(TILE_SIZE))) ?
               $signed((COORD_W+2)'(TILE_SIZE)) : last1;
    visible  = y_in && (first_s < last_s);
    lo_c     = first_s[LANE_W-1:0];
    n_c      = last_s[CNT_W-1:0] - {1'b0, lo_c};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= 1'b0;
    end else if (ready2) begin
      row_valid <= v1 && visible;
    end
    if (ready2 && v1 && visible) begin
      row.y        <= y1;
      row.x0       <= $signed({tx1[COORD_W-1], tx1})
                      + $signed({{(COORD_W+1-LANE_W){1'b0}}, lo_c});
      row.lo       <= lo_c;
      row.n        <= n_c;
      row.pixels   <= pix1;
      row.mask     <= mask1;
      row.use_mask <= um1;
    end
  end

  a_run_fits: assert property (@(posedge clk) disable iff (rst)
    row_valid |-> (row.n != '0) && ({1'b0, row.lo} + row.n <= CNT_W'(TILE_SIZE)))
    else $error("clipped run empty or past the tile edge");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (v1 && !ready2) |=> (v1 && $stable(y1) && $stable(first1)))
    else $error("stage 1 changed while stalled");

  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    (row_valid && !row_ready) |=> (row_valid && $stable(row)))
    else $error("clipped row changed while stalled");

endmodule

### src/cmtb_write.sv
// Write stages: line multiply and lane shift, then address add into the output register.
module cmtb_write
  import cmtb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          row_valid,
  output logic          row_ready,
  input  row_t          row,
  cmtb_write_if.source  out_item
);

  logic                 v3;
  logic [ADDR_W-1:0]    prod3;
  logic [ADDR_W-1:0]    x03;
  logic [PIX_W-1:0]     pix3;
  logic [TILE_SIZE-1:0] en3;

  logic ready3;
  logic ready4;

  assign ready4    = !out_item.valid || out_item.ready;
  assign ready3    = !v3 || ready4;
  assign row_ready = ready3;

  logic signed [COORD_W+SIZE_W+1:0] prod_c;
  logic [PIX_W-1:0]                 shifted;
  logic [PIX_W-1:0]                 pix_c;
  logic [TILE_SIZE-1:0]             run_en;
  logic [TILE_SIZE-1:0]             mask_sh;

  always_comb begin
    prod_c  = row.y * $signed({1'b0, cfg.line_width});
    shifted = row.pixels >> {row.lo, 3'b000};
    mask_sh = row.mask >> row.lo;
    for (int k = 0; k < TILE_SIZE; k++) begin
      run_en[k]        = CNT_W'(k) < row.n;
      pix_c[k*8 +: 8]  = run_en[k] ? shifted[k*8 +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= row_valid;
    end
    if (ready3 && row_valid) begin
      prod3 <= prod_c[ADDR_W-1:0];
      x03   <= {{(ADDR_W-COORD_W-1){row.x0[COORD_W]}}, row.x0};
      pix3  <= pix_c;
      en3   <= row.use_mask ? (run_en & mask_sh) : run_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_item.valid <= 1'b0;
    end else if (ready4) begin
      out_item.valid <= v3;
    end
    if (ready4 && v3) begin
      out_item.write_address <= prod3 + x03;
      out_item.write_pixels  <= pix3;
      out_item.write_enables <= en3;
    end
  end

  a_s3_hold: assert property (@(posedge clk) disable iff (rst)
    (v3 && !ready4) |=> (v3 && $stable(prod3) && $stable(x03) && $stable(en3)))
    else $error("stage 3 changed while stalled");

  a_s3_fill: assert property (@(posedge clk) disable iff (rst)
    (!v3 && !out_item.valid) |=> !out_item.valid)
    else $error("write appeared with an empty pipeline");

  a_s3_load: assert property (@(posedge clk) disable iff (rst)
    (row_valid && row_ready) |=> v3)
    else $error("clipped row lost on transfer into stage 3");

endmodule

### src/clipped_masked_tile_row_blit_unit.sv
// Top level: configuration registers, clip stages and write stages.
// An input transfer passes the stage 1, stage 2, stage 3 and output registers before the write is valid.
// Throughput: one row per cycle while the write side is ready; a stall holds only the full stages.
// Rows with no visible pixel are dropped in stage 2 and give no write.
// Reset (rst, synchronous) empties the pipeline and loads clip 0,0,320x240, stride 320.
module clipped_masked_tile_row_blit_unit
  import cmtb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  cmtb_row_if.sink             in_item,
  cmtb_write_if.source         out_item
);

  cfg_t cfg;
  logic row_valid;
  logic row_ready;
  row_t row;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clip_left   <= CLIP_LEFT_RST;
      cfg.clip_top    <= CLIP_TOP_RST;
      cfg.clip_width  <= CLIP_WIDTH_RST;
      cfg.clip_height <= CLIP_HEIGHT_RST;
      cfg.line_width  <= LINE_WIDTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CLIP_LEFT:   cfg.clip_left   <= $signed(cfg_data);
        REG_CLIP_TOP:    cfg.clip_top    <= $signed(cfg_data);
        REG_CLIP_WIDTH:  cfg.clip_width  <= cfg_data[SIZE_W-1:0];
        REG_CLIP_HEIGHT: cfg.clip_height <= cfg_data[SIZE_W-1:0];
        REG_LINE_WIDTH:  cfg.line_width  <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  cmtb_clip u_clip (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_item   (in_item),
    .row_valid (row_valid),
    .row_ready (row_ready),
    .row       (row)
  );

  cmtb_write u_write (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .row_valid (row_valid),
    .row_ready (row_ready),
    .row       (row),
    .out_item  (out_item)
  );

endmodule

### verif/tb_blit_pkg.sv
// Row and write types plus the framebuffer write checker for the tile row blitter bench.
`timescale 1ns / 100ps
package tb_blit_pkg;
  import cmtb_pkg::*;

  typedef struct packed {
    logic signed [COORD_W-1:0] tile_x;
    logic signed [COORD_W-1:0] tile_y;
    logic [LANE_W-1:0]         row_index;
    logic [PIX_W-1:0]          row_pixels;
    logic [TILE_SIZE-1:0]      row_mask;
    logic                      use_mask;
  } tile_row_t;

  typedef struct packed {
    logic [ADDR_W-1:0]    addr;
    logic [PIX_W-1:0]     pixels;
    logic [TILE_SIZE-1:0] enables;
  } fb_write_t;

  class fb_write_checker;
    longint    clip_left;
    longint    clip_top;
    longint    clip_width;
    longint    clip_height;
    longint    line_width;
    fb_write_t pending_writes[$];
    int        errors;

    function new();
      clip_left   = longint'(CLIP_LEFT_RST);
      clip_top    = longint'(CLIP_TOP_RST);
      clip_width  = longint'(CLIP_WIDTH_RST);
      clip_height = longint'(CLIP_HEIGHT_RST);
      line_width  = longint'(LINE_WIDTH_RST);
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_CLIP_LEFT:   clip_left   = longint'($signed(data[COORD_W-1:0]));
        REG_CLIP_TOP:    clip_top    = longint'($signed(data[COORD_W-1:0]));
        REG_CLIP_WIDTH:  clip_width  = longint'(data[SIZE_W-1:0]);
        REG_CLIP_HEIGHT: clip_height = longint'(data[SIZE_W-1:0]);
        REG_LINE_WIDTH:  line_width  = longint'(data[SIZE_W-1:0]);
        default: ;  // spare indexes are ignored
      endcase
    endfunction

    // Clip one row; returns 0 when the row gives no framebuffer write.
    function bit blit_row(input tile_row_t r, output fb_write_t w);
      longint     tx;
      longint     y;
      longint     first;
      longint     last;
      longint     addr;
      int         lo;
      int         n;
      logic [8:0] en;
      w  = '0;
      tx = longint'($signed(r.tile_x));
      y  = longint'($signed(r.tile_y)) + longint'(r.row_index);
      if (y < clip_top || y >= clip_top + clip_height) return 0;
      first = clip_left - tx;
      last  = clip_left + clip_width - tx;
      if (first < 0) first = 0;
      if (last > TILE_SIZE) last = TILE_SIZE;
      if (first >= last) return 0;
      lo = int'(first);
      n  = int'(last - first);
      w.pixels = r.row_pixels >> (8 * lo);
      if (n < TILE_SIZE) w.pixels &= (PIX_W'(1) << (8 * n)) - PIX_W'(1);
      en = (9'd1 << n) - 9'd1;
      if (r.use_mask) en &= {1'b0, r.row_mask >> lo};
      w.enables = en[TILE_SIZE-1:0];
      // exact signed address, truncated like a 24-bit adder
      addr   = y * line_width + tx + first;
      w.addr = addr[ADDR_W-1:0];
      return 1;
    endfunction

    function void take_row(tile_row_t r);
      fb_write_t w;
      if (blit_row(r, w)) pending_writes.push_back(w);
    endfunction

    function void check_write(fb_write_t got);
      fb_write_t want;
      if (pending_writes.size() == 0) begin
        errors++;
        $display("%0t: unexpected write: addr=%h pixels=%h enables=%b",
                 $time, got.addr, got.pixels, got.enables);
        return;
      end
      want = pending_writes.pop_front();
      if (got.addr !== want.addr) begin
        errors++;
        $display("%0t: write_address expected %h actual %h", $time, want.addr, got.addr);
      end
      if (got.pixels !== want.pixels) begin
        errors++;
        $display("%0t: write_pixels expected %h actual %h", $time, want.pixels, got.pixels);
      end
      if (got.enables !== want.enables) begin
        errors++;
        $display("%0t: write_enables expected %b actual %b", $time, want.enables,
                 got.enables);
      end
    endfunction
  endclass

endpackage

### verif/tb_top.sv
// Top-level bench for clipped_masked_tile_row_blit_unit: stimulus, handshakes and final verdict.
`timescale 1ns / 100ps
module tb_top;
  import cmtb_pkg::*;
  import tb_blit_pkg::*;

  localparam int LATENCY = 4;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  bit                   idle_on = 1'b1;
  fb_write_checker      fb_check;

  cmtb_row_if   row_ch ();
  cmtb_write_if wr_ch ();

  clipped_masked_tile_row_blit_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (row_ch),
    .out_item  (wr_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // write side back-pressure in random bursts
  initial begin : write_ready
    int hold;
    hold = 0;
    wr_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && hold == 0 && $urandom_range(0, 11) == 0) hold = $urandom_range(1, 16);
      if (hold > 0) begin
        wr_ch.ready = 1'b0;
        hold--;
      end else begin
        wr_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && wr_ch.valid && wr_ch.ready)
      fb_check.check_write({wr_ch.write_address, wr_ch.write_pixels, wr_ch.write_enables});
  end

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    fb_check.write_reg(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_clip(input int left, input int top, input int w, input int h,
                          input int lw);
    set_reg(REG_CLIP_LEFT, CFG_W'(left));
    set_reg(REG_CLIP_TOP, CFG_W'(top));
    set_reg(REG_CLIP_WIDTH, CFG_W'(w));
    set_reg(REG_CLIP_HEIGHT, CFG_W'(h));
    set_reg(REG_LINE_WIDTH, CFG_W'(lw));
    // indexes past the register list must leave everything alone
    for (int i = int'(REG_LINE_WIDTH) + 1; i < 2 ** CFG_IDX_W; i++)
      set_reg(CFG_IDX_W'(i), CFG_W'($urandom));
  endtask

  // Hold off until every expected write is out, then let dropped rows flush.
  task automatic drain();
    int seen;
    row_ch.valid = 1'b0;
    while (fb_check.pending_writes.size() != 0) @(negedge clk);
    seen = 0;
    for (int c = 0; c < 64 && seen < 2 * LATENCY; c++) begin
      @(posedge clk);
      if (wr_ch.ready) seen++;
    end
    @(negedge clk);
  endtask

  task automatic send_row(input tile_row_t r);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      row_ch.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    row_ch.valid      = 1'b1;
    row_ch.tile_x     = r.tile_x;
    row_ch.tile_y     = r.tile_y;
    row_ch.row_index  = r.row_index;
    row_ch.row_pixels = r.row_pixels;
    row_ch.row_mask   = r.row_mask;
    row_ch.use_mask   = r.use_mask;
    @(posedge clk);
    while (!row_ch.ready) @(posedge clk);
    fb_check.take_row(r);
    @(negedge clk);
  endtask

  function automatic tile_row_t row_of(int tx, int ty, int row, logic [PIX_W-1:0] pix,
                                       logic [TILE_SIZE-1:0] mask, bit um);
    tile_row_t r;
    r.tile_x     = COORD_W'(tx);
    r.tile_y     = COORD_W'(ty);
    r.row_index  = LANE_W'(row);
    r.row_pixels = pix;
    r.row_mask   = mask;
    r.use_mask   = um;
    return r;
  endfunction

  // Offset from a clip edge: near the near edge, near the far edge, or anywhere across.
  function automatic int edge_offset(longint span);
    case ($urandom_range(0, 2))
      0:       return int'($urandom_range(0, 20)) - 10;
      1:       return int'(span) + int'($urandom_range(0, 16)) - 12;
      default: return int'($urandom_range(0, int'(span) + 17)) - 10;
    endcase
  endfunction

  function automatic tile_row_t random_row();
    tile_row_t r;
    r.row_pixels = {$urandom, $urandom};
    r.row_mask   = TILE_SIZE'($urandom);
    r.use_mask   = 1'($urandom);
    r.row_index  = LANE_W'($urandom);
    if ($urandom_range(0, 9) < 8) begin
      r.tile_x = COORD_W'(fb_check.clip_left + longint'(edge_offset(fb_check.clip_width)));
      r.tile_y = COORD_W'(fb_check.clip_top + longint'(edge_offset(fb_check.clip_height)));
    end else begin
      r.tile_x = COORD_W'($urandom);
      r.tile_y = COORD_W'($urandom);
    end
    return r;
  endfunction

  task automatic run_rows(input int count);
    repeat (count) send_row(random_row());
  endtask

  initial begin : stimulus
    logic [PIX_W-1:0] ramp;
    fb_check          = new();
    ramp              = 64'h0706_0504_0302_0100;
    row_ch.valid      = 1'b0;
    row_ch.tile_x     = '0;
    row_ch.tile_y     = '0;
    row_ch.row_index  = '0;
    row_ch.row_pixels = '0;
    row_ch.row_mask   = '0;
    row_ch.use_mask   = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // reset clip 0,0 320x240, stride 320
    send_row(row_of(0, 0, 0, ramp, 8'h00, 1'b0));
    send_row(row_of(-3, 0, 1, '1, 8'hA5, 1'b1));             // left clipped
    send_row(row_of(316, 5, 2, 64'h1122_3344_5566_7788, 8'hFF, 1'b1));  // right clipped
    send_row(row_of(-8, 10, 0, ramp, 8'hFF, 1'b0));          // just left of rectangle
    send_row(row_of(320, 10, 0, ramp, 8'hFF, 1'b0));         // just right of rectangle
    send_row(row_of(-7, 10, 3, '1, 8'h80, 1'b1));            // single column at lane 7
    send_row(row_of(319, 10, 4, '1, 8'h01, 1'b1));           // single column at lane 0
    send_row(row_of(0, -1, 0, ramp, 8'hFF, 1'b0));           // above top
    send_row(row_of(0, -1, 1, ramp, 8'hFF, 1'b0));           // first line
    send_row(row_of(8, 233, 7, ramp, 8'hFF, 1'b0));          // below bottom
    send_row(row_of(8, 233, 6, ramp, 8'h3C, 1'b1));          // last line
    send_row(row_of(32767, 0, 0, '1, 8'hFF, 1'b0));
    send_row(row_of(-32768, 0, 0, '1, 8'hFF, 1'b0));
    send_row(row_of(0, 32767, 7, '1, 8'hFF, 1'b0));
    send_row(row_of(0, -32768, 7, '1, 8'hFF, 1'b0));
    send_row(row_of(100, 100, 5, '0, 8'h00, 1'b1));          // everything masked off
    send_row(row_of(100, 100, 5, '1, 8'h00, 1'b0));
    send_row(row_of(200, 50, 7, 64'hDEAD_BEEF_0123_4567, 8'h5A, 1'b1));
    send_row(row_of(312, 239, 0, '1, 8'hFF, 1'b1));
    send_row(row_of(-4, 239, 0, 64'h8899_AABB_CCDD_EEFF, 8'hF0, 1'b1));
    run_rows(75);
    drain();
    run_rows(75);

    drain();
    set_clip(-32768, -32768, 4096, 4096, 4096);
    run_rows(150);

    drain();
    set_clip(32767, 32767, 4096, 4096, 1);
    run_rows(150);

    drain();
    set_clip(0, 0, 0, 4096, 4096);                           // zero width
    run_rows(40);

    drain();
    set_clip(-5, -5, 100, 0, 77);                            // zero height
    run_rows(40);

    drain();
    set_clip(100, -50, 17, 9, 0);                            // zero stride
    run_rows(150);

    for (int p = 0; p < 4; p++) begin
      drain();
      set_clip(int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768,
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4096) : $urandom_range(1, 40),
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4096) : $urandom_range(1, 40),
               $urandom_range(1, 4096));
      if (p == 3) idle_on = 1'b0;
      run_rows(110);
    end

    drain();
    if (fb_check.errors == 0 && fb_check.pending_writes.size() == 0) begin
      $display("PASS clipped_masked_tile_row_blit_unit");
    end else begin
      $display("FAIL clipped_masked_tile_row_blit_unit");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("FAIL clipped_masked_tile_row_blit_unit");
    $finish;
  end

endmodule
